>>> rtl/core/hvf_pkg.sv
// hvf_pkg: shared types, constants and helpers of the viterbi forward pass
// used by hvf_divider, hvf_front, hvf_back and the top level; depends on nothing
`timescale 1ns / 1ps

package hvf_pkg;

    localparam int DEFAULT_MAX_STATES = 16;
    localparam int PROB_W = 32;
    localparam int SUM_W  = 37;
    localparam int CNT_W  = 5;
    localparam int DIV_W  = 65;

    localparam logic [PROB_W-1:0] ONES32 = '1;

    // input function codes
    localparam logic [1:0] FUNC_PRIOR = 2'd0;
    localparam logic [1:0] FUNC_TRANS = 2'd1;
    localparam logic [1:0] FUNC_OBS   = 2'd2;
    localparam logic [1:0] FUNC_START = 2'd3;

    // register indexes
    localparam logic REG_NUM_STATES  = 1'b0;
    localparam logic REG_SCALE_ENABLE = 1'b1;

    typedef struct packed {
        logic [1:0]        func;
        logic [3:0]        from_state;
        logic [3:0]        to_state;
        logic [PROB_W-1:0] prob;
    } hvf_op_t;

    typedef struct packed {
        logic [CNT_W-1:0] q;
        logic             scale_en;
    } hvf_cfg_t;

    // states in use: zero acts as one, top clipped to the table depth
    function automatic logic [CNT_W-1:0] states_in_use(input logic [CNT_W-1:0] n,
                                                       input logic [CNT_W-1:0] lim);
        logic [CNT_W-1:0] r;
        r = n;
        if (r == '0)
        begin
            r = CNT_W'(1);
        end
        if (r > lim)
        begin
            r = lim;
        end
        return r;
    endfunction

endpackage

>>> rtl/core/hvf_ram.sv
// hvf_ram: generic single write port, single read port ram with registered read
// depends on nothing
`timescale 1ns / 1ps

module hvf_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

>>> rtl/core/hvf_divider.sv
// hvf_divider: restoring divider, one quotient bit per cycle
// uses hvf_pkg for widths
`timescale 1ns / 1ps

module hvf_divider (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [hvf_pkg::DIV_W-1:0] dividend,
    input  logic [hvf_pkg::SUM_W-1:0] divisor,
    output logic                     done,
    output logic [hvf_pkg::DIV_W-1:0] quotient
);
    import hvf_pkg::*;

    localparam int STEP_W = $clog2(DIV_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [SUM_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  qd_reg, qd_next;
    logic [SUM_W-1:0]  dsr_reg, dsr_next;
    logic [SUM_W:0]    trial;

    // one shift, compare and subtract per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        qd_next   = qd_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg, qd_reg[DIV_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            qd_next   = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = SUM_W'(trial - {1'b0, dsr_reg});
                qd_next  = {qd_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[SUM_W-1:0];
                qd_next  = {qd_reg[DIV_W-2:0], 1'b0};
            end
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        qd_reg  <= qd_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = qd_reg;

endmodule

>>> rtl/core/hvf_front.sv
// hvf_front: accepts input transactions, drops out-of-range ones, queues the rest
// uses hvf_pkg for the op and config structs
`timescale 1ns / 1ps

module hvf_front #(
    parameter int MAX_STATES = hvf_pkg::DEFAULT_MAX_STATES
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  hvf_pkg::hvf_cfg_t        cfg,
    input  logic                     item_valid,
    output logic                     item_ready,
    input  logic [1:0]               func,
    input  logic [3:0]               from_state,
    input  logic [3:0]               to_state,
    input  logic [hvf_pkg::PROB_W-1:0] prob_value,
    output logic                     op_valid,
    input  logic                     op_ready,
    output hvf_pkg::hvf_op_t         op
);
    import hvf_pkg::*;

    localparam int NS = (MAX_STATES < 16) ? MAX_STATES : 16;
    localparam logic [CNT_W-1:0] NS_C = CNT_W'(NS);

    logic [1:0] count_reg, count_next;
    hvf_op_t    slot_reg [2];
    hvf_op_t    slot_next [2];
    logic       keep;
    logic       push, pop;
    hvf_op_t    entry;

    // classify: keep only transactions that do something
    always_comb
    begin
        entry.func       = func;
        entry.from_state = from_state;
        entry.to_state   = to_state;
        entry.prob       = prob_value;
        case (func)
            FUNC_PRIOR: keep = ({1'b0, to_state} < NS_C);
            FUNC_TRANS: keep = ({1'b0, to_state} < NS_C) && ({1'b0, from_state} < NS_C);
            FUNC_OBS:   keep = ({1'b0, to_state} < cfg.q);
            default:    keep = 1'b1;
        endcase
    end

    assign item_ready = (count_reg != 2'd2);
    assign op_valid   = (count_reg != 2'd0);
    assign op         = slot_reg[0];
    assign pop        = op_valid && op_ready;
    assign push       = item_valid && item_ready && keep;

    // two-entry queue, head in slot 0
    always_comb
    begin
        slot_next[0] = slot_reg[0];
        slot_next[1] = slot_reg[1];
        count_next   = count_reg;
        if (pop)
        begin
            slot_next[0] = slot_reg[1];
        end
        if (push)
        begin
            if (count_reg == 2'd0 || (count_reg == 2'd1 && pop))
            begin
                slot_next[0] = entry;
            end
            else
            begin
                slot_next[1] = entry;
            end
        end
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg[0] <= slot_next[0];
        slot_reg[1] <= slot_next[1];
    end

endmodule

>>> rtl/core/hvf_back.sv
// hvf_back: sequencer that runs loads, the predecessor scan and frame output
// uses hvf_pkg, hvf_ram for the transition table and hvf_divider for scaling
`timescale 1ns / 1ps

module hvf_back #(
    parameter int MAX_STATES = hvf_pkg::DEFAULT_MAX_STATES
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  hvf_pkg::hvf_cfg_t          cfg,
    input  logic                       op_valid,
    output logic                       op_ready,
    input  hvf_pkg::hvf_op_t           op,
    output logic                       result_valid,
    input  logic                       result_ready,
    output logic [3:0]                 state_index,
    output logic [hvf_pkg::PROB_W-1:0] best_score,
    output logic [4:0]                 back_pointer,
    output logic [63:0]                frame_scale,
    output logic                       last_of_frame
);
    import hvf_pkg::*;

    localparam int NS = (MAX_STATES < 16) ? MAX_STATES : 16;
    localparam int IW = $clog2(NS);
    localparam int AW = $clog2(NS * NS);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCAN   = 4'd1;
    localparam logic [3:0] S_FMUL   = 4'd2;
    localparam logic [3:0] S_SCORE  = 4'd3;
    localparam logic [3:0] S_RSTART = 4'd4;
    localparam logic [3:0] S_RWAIT  = 4'd5;
    localparam logic [3:0] S_NSTART = 4'd6;
    localparam logic [3:0] S_NWAIT  = 4'd7;
    localparam logic [3:0] S_EMIT   = 4'd8;

    logic [3:0]        state_reg, state_next;
    logic              first_reg, first_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [3:0]        to_reg, to_next;
    logic [PROB_W-1:0] prob_reg, prob_next;
    logic [CNT_W-1:0]  iss_k_reg, iss_k_next;
    logic              v1_reg, v1_next, v2_reg, v2_next;
    logic [CNT_W-1:0]  k1_reg, k1_next, k2_reg, k2_next;
    logic [63:0]       best_reg, best_next;
    logic [4:0]        bptr_reg, bptr_next;
    logic [CNT_W-1:0]  emit_k_reg, emit_k_next;
    logic [63:0]       scale_reg, scale_next;
    logic [PROB_W-1:0] norm_reg, norm_next;
    logic [63:0]       prod_reg;

    logic              out_valid_reg, out_valid_next;
    logic [3:0]        out_index_reg;
    logic [PROB_W-1:0] out_score_reg;
    logic [4:0]        out_ptr_reg;
    logic [63:0]       out_scale_reg;
    logic              out_last_reg;

    logic [PROB_W-1:0] prior_reg [NS];
    logic [PROB_W-1:0] prev_reg  [NS];
    logic [PROB_W-1:0] cur_reg   [NS];
    logic [4:0]        ptr_reg   [NS];

    logic [PROB_W-1:0] mul_a, mul_b;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [PROB_W-1:0] ram_rdata;
    logic              div_start, div_done;
    logic [DIV_W-1:0]  div_dividend, div_quot;
    logic [CNT_W-1:0]  q_last;
    logic [IW-1:0]     to_idx, head_idx, k1_idx, emit_idx;
    logic              slot_free, out_load;
    logic [PROB_W-1:0] emit_val;
    logic              prior_we, score_we;

    assign q_last    = cfg.q - CNT_W'(1);
    assign to_idx    = to_reg[IW-1:0];
    assign head_idx  = op.to_state[IW-1:0];
    assign k1_idx    = k1_reg[IW-1:0];
    assign emit_idx  = emit_k_reg[IW-1:0];
    assign slot_free = !out_valid_reg || result_ready;
    assign emit_val  = cfg.scale_en ? norm_reg : cur_reg[emit_idx];
    assign op_ready  = (state_reg == S_IDLE);

    // transition table
    assign ram_we    = (state_reg == S_IDLE) && op_valid && (op.func == FUNC_TRANS);
    assign ram_waddr = AW'(int'(op.from_state) * NS + int'(op.to_state));
    assign ram_raddr = AW'(int'(iss_k_reg) * NS + int'(to_reg));

    hvf_ram #(
        .WIDTH (PROB_W),
        .DEPTH (NS * NS)
    ) u_trans_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (op.prob),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared divider: reciprocal of the sum, then each score over the sum
    assign div_start    = (state_reg == S_RSTART && sum_reg > SUM_W'(1))
                       || (state_reg == S_NSTART && sum_reg != '0);
    assign div_dividend = (state_reg == S_RSTART) ? {1'b1, 64'd0}
                                                  : {1'b0, cur_reg[emit_idx], 32'd0};

    hvf_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (sum_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            S_IDLE:
            begin
                mul_a = prior_reg[head_idx];
                mul_b = op.prob;
            end
            S_SCAN:
            begin
                mul_a = prev_reg[k1_idx];
                mul_b = ram_rdata;
            end
            default:
            begin
                mul_a = best_reg[63:32];
                mul_b = prob_reg;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        first_next  = first_reg;
        sum_next    = sum_reg;
        to_next     = to_reg;
        prob_next   = prob_reg;
        iss_k_next  = iss_k_reg;
        v1_next     = 1'b0;
        v2_next     = 1'b0;
        k1_next     = k1_reg;
        k2_next     = k2_reg;
        best_next   = best_reg;
        bptr_next   = bptr_reg;
        emit_k_next = emit_k_reg;
        scale_next  = scale_reg;
        norm_next   = norm_reg;
        out_load    = 1'b0;
        prior_we    = 1'b0;
        score_we    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (op_valid)
                begin
                    to_next   = op.to_state;
                    prob_next = op.prob;
                    case (op.func)
                        FUNC_PRIOR: prior_we = 1'b1;
                        FUNC_START:
                        begin
                            first_next = 1'b1;
                            sum_next   = '0;
                        end
                        FUNC_OBS:
                        begin
                            iss_k_next = '0;
                            state_next = first_reg ? S_SCORE : S_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN:
            begin
                // issue reads, multiply the registered ram data, compare the registered product
                if (iss_k_reg < cfg.q)
                begin
                    v1_next    = 1'b1;
                    k1_next    = iss_k_reg;
                    iss_k_next = iss_k_reg + CNT_W'(1);
                end
                v2_next = v1_reg;
                k2_next = k1_reg;
                if (v2_reg)
                begin
                    if (k2_reg == '0 || prod_reg > best_reg)
                    begin
                        best_next = prod_reg;
                        bptr_next = 5'(k2_reg) + 5'd1;
                    end
                    if (k2_reg == q_last)
                    begin
                        state_next = S_FMUL;
                    end
                end
            end
            S_FMUL:
            begin
                state_next = S_SCORE;
            end
            S_SCORE:
            begin
                score_we = 1'b1;
                sum_next = SUM_W'(sum_reg + SUM_W'(prod_reg[63:32]));
                if ({1'b0, to_reg} == q_last)
                begin
                    emit_k_next = '0;
                    scale_next  = '0;
                    state_next  = cfg.scale_en ? S_RSTART : S_EMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_RSTART:
            begin
                if (sum_reg > SUM_W'(1))
                begin
                    state_next = S_RWAIT;
                end
                else
                begin
                    scale_next = '1;
                    state_next = S_NSTART;
                end
            end
            S_RWAIT:
            begin
                if (div_done)
                begin
                    scale_next = div_quot[63:0];
                    state_next = S_NSTART;
                end
            end
            S_NSTART:
            begin
                if (sum_reg != '0)
                begin
                    state_next = S_NWAIT;
                end
                else
                begin
                    norm_next  = '0;
                    state_next = S_EMIT;
                end
            end
            S_NWAIT:
            begin
                if (div_done)
                begin
                    norm_next  = (div_quot > DIV_W'(ONES32)) ? ONES32 : div_quot[31:0];
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_load = 1'b1;
                    if (emit_k_reg == q_last)
                    begin
                        first_next = 1'b0;
                        sum_next   = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        emit_k_next = emit_k_reg + CNT_W'(1);
                        state_next  = cfg.scale_en ? S_NSTART : S_EMIT;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        out_valid_next = (out_valid_reg && !result_ready) || out_load;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            first_reg     <= 1'b1;
            sum_reg       <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            first_reg     <= first_next;
            sum_reg       <= sum_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers and state tables
    always_ff @(posedge clk)
    begin
        to_reg     <= to_next;
        prob_reg   <= prob_next;
        iss_k_reg  <= iss_k_next;
        k1_reg     <= k1_next;
        k2_reg     <= k2_next;
        best_reg   <= best_next;
        bptr_reg   <= bptr_next;
        emit_k_reg <= emit_k_next;
        scale_reg  <= scale_next;
        norm_reg   <= norm_next;
        prod_reg   <= 64'(mul_a) * 64'(mul_b);
        if (prior_we)
        begin
            prior_reg[head_idx] <= op.prob;
        end
        if (score_we)
        begin
            cur_reg[to_idx] <= prod_reg[63:32];
            ptr_reg[to_idx] <= first_reg ? 5'd0 : bptr_reg;
        end
        if (out_load)
        begin
            cur_reg[emit_idx]  <= emit_val;
            prev_reg[emit_idx] <= emit_val;
            out_index_reg      <= emit_k_reg[3:0];
            out_score_reg      <= emit_val;
            out_ptr_reg        <= ptr_reg[emit_idx];
            out_scale_reg      <= scale_reg;
            out_last_reg       <= (emit_k_reg == q_last);
        end
    end

    assign result_valid  = out_valid_reg;
    assign state_index   = out_index_reg;
    assign best_score    = out_score_reg;
    assign back_pointer  = out_ptr_reg;
    assign frame_scale   = out_scale_reg;
    assign last_of_frame = out_last_reg;

endmodule

>>> rtl/core/hmm_viterbi_forward_pass.sv
// hmm_viterbi_forward_pass: top level, register port, front queue and back sequencer
// uses hvf_pkg, hvf_front and hvf_back
`timescale 1ns / 1ps

// Viterbi forward pass for a hidden Markov model in unsigned 0.32 fixed point.
// Prior and transition loads and start transactions are handled directly in the
// back sequencer's idle state. A first-frame observation skips the scan;
// a later observation first runs the scan over the q states in use, which
// reads one transition entry per cycle and feeds the single shared
// 32x32 multiplier. When the last state in use is observed the frame's q
// results leave through an output register at one per cycle while the receiver
// is ready; with scaling on, the reciprocal and each normalised score go through
// the one-bit-per-cycle divider first. A two-entry queue ahead of the sequencer
// keeps taking transactions while it works, until the queue is full. No clearing
// pass is needed after reset.

module hmm_viterbi_forward_pass #(
    parameter int MAX_STATES = hvf_pkg::DEFAULT_MAX_STATES
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       item_valid,
    output logic                       item_ready,
    input  logic [1:0]                 func,
    input  logic [3:0]                 from_state,
    input  logic [3:0]                 to_state,
    input  logic [hvf_pkg::PROB_W-1:0] prob_value,
    output logic                       result_valid,
    input  logic                       result_ready,
    output logic [3:0]                 state_index,
    output logic [hvf_pkg::PROB_W-1:0] best_score,
    output logic [4:0]                 back_pointer,
    output logic [63:0]                frame_scale,
    output logic                       last_of_frame
);
    import hvf_pkg::*;

    localparam int NS = (MAX_STATES < 16) ? MAX_STATES : 16;
    localparam logic [CNT_W-1:0] NS_C = CNT_W'(NS);

    logic [4:0] num_states_reg, num_states_next;
    logic       scale_en_reg, scale_en_next;
    logic       reg_idx;
    hvf_cfg_t   cfg;
    logic       op_valid, op_ready;
    hvf_op_t    op;

    // register port
    assign pready  = 1'b1;
    assign reg_idx = paddr[2];

    always_comb
    begin
        num_states_next = num_states_reg;
        scale_en_next   = scale_en_reg;
        if (psel && penable && pwrite)
        begin
            case (reg_idx)
                REG_NUM_STATES:   num_states_next = pwdata[4:0];
                REG_SCALE_ENABLE: scale_en_next   = pwdata[0];
                default: ;
            endcase
        end
        case (reg_idx)
            REG_NUM_STATES:   prdata = {27'd0, num_states_reg};
            REG_SCALE_ENABLE: prdata = {31'd0, scale_en_reg};
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_states_reg <= 5'd16;
            scale_en_reg   <= 1'b0;
        end
        else
        begin
            num_states_reg <= num_states_next;
            scale_en_reg   <= scale_en_next;
        end
    end

    assign cfg.q        = states_in_use(num_states_reg, NS_C);
    assign cfg.scale_en = scale_en_reg;

    // front: accept and classify
    hvf_front #(
        .MAX_STATES (MAX_STATES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .func       (func),
        .from_state (from_state),
        .to_state   (to_state),
        .prob_value (prob_value),
        .op_valid   (op_valid),
        .op_ready   (op_ready),
        .op         (op)
    );

    // back: execute and emit
    hvf_back #(
        .MAX_STATES (MAX_STATES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .op_valid      (op_valid),
        .op_ready      (op_ready),
        .op            (op),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .state_index   (state_index),
        .best_score    (best_score),
        .back_pointer  (back_pointer),
        .frame_scale   (frame_scale),
        .last_of_frame (last_of_frame)
    );

    // the final transaction of a frame reports the last state in use
    a_last_state: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_of_frame |-> {1'b0, state_index} == cfg.q - CNT_W'(1))
        else $error("last_of_frame on a state other than the last in use");

    // back pointers never point past the state tables
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> back_pointer <= NS_C)
        else $error("back pointer beyond the state count");

endmodule

>>> bench/hmm_viterbi_forward_pass_tb.sv
// hmm_viterbi_forward_pass_tb: self-checking bench for the viterbi forward pass
// drives loads, starts and observations, predicts each frame and checks every result
// depends on hvf_pkg and hmm_viterbi_forward_pass
`timescale 1ns / 1ps

module hmm_viterbi_forward_pass_tb;

    import hvf_pkg::*;

    localparam int          CYCLE_LIMIT = 3000000;
    localparam int          SETTLE      = 300;
    localparam logic [2:0]  ADDR_NUM_STATES  = {1'b0, REG_NUM_STATES, 1'b0} << 1;
    localparam logic [2:0]  ADDR_SCALE_EN    = {1'b0, REG_SCALE_ENABLE, 1'b0} << 1;

    typedef enum logic { ROW_ITEM, ROW_REG } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [1:0]  fn;
        logic [3:0]  src;
        logic [3:0]  dst;
        logic [31:0] val;
        bit          glance;
        logic [31:0] g_score;
        logic [4:0]  g_ptr;
        logic [63:0] g_scale;
    } stim_row_t;

    typedef struct {
        logic [3:0]  st;
        logic [31:0] score;
        logic [4:0]  ptr;
        logic [63:0] scale;
        logic        last;
    } frame_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        item_valid = 1'b0;
    logic        item_ready;
    logic [1:0]  func = '0;
    logic [3:0]  from_state = '0;
    logic [3:0]  to_state = '0;
    logic [31:0] prob_value = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [3:0]  state_index;
    logic [31:0] best_score;
    logic [4:0]  back_pointer;
    logic [63:0] frame_scale;
    logic        last_of_frame;

    hmm_viterbi_forward_pass i_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .item_valid(item_valid), .item_ready(item_ready),
        .func(func), .from_state(from_state), .to_state(to_state),
        .prob_value(prob_value),
        .result_valid(result_valid), .result_ready(result_ready),
        .state_index(state_index), .best_score(best_score),
        .back_pointer(back_pointer), .frame_scale(frame_scale),
        .last_of_frame(last_of_frame)
    );

    always #6 clk = ~clk;

    // predictor state, mirrors the block's tables and registers
    logic [31:0]   prior_tab [16];
    logic [31:0]   trans_tab [256];
    logic [31:0]   prev_score [16];
    logic [31:0]   cur_score [16];
    logic [4:0]    cur_ptr [16];
    bit            prior_w [16];
    bit            trans_w [256];
    bit            prev_w [16];
    bit            cur_w [16];
    logic [36:0]   frame_sum;
    bit            first_frame;
    logic [4:0]    num_states_reg;
    logic          scale_reg;

    frame_result_t frame_results_q[$];
    int            mismatches = 0;
    int            cycles = 0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            recv_hold = 0;
    int            obs_next = 0;

    function automatic int states_used();
        if (num_states_reg == 0)
        begin
            return 1;
        end
        return (num_states_reg > 16) ? 16 : int'(num_states_reg);
    endfunction

    function automatic logic [63:0] prod64(input logic [31:0] a, input logic [31:0] b);
        return {32'b0, a} * {32'b0, b};
    endfunction

    function automatic logic [63:0] frame_reciprocal(input logic [36:0] s);
        logic [64:0] r;
        if (s <= 37'd1)
        begin
            return '1;
        end
        r = {1'b1, 64'b0} / {28'b0, s};
        return r[63:0];
    endfunction

    function automatic logic [31:0] normalised(input logic [31:0] sc, input logic [36:0] s);
        logic [63:0] v;
        if (s == '0)
        begin
            return '0;
        end
        v = {sc, 32'b0} / {27'b0, s};
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    // update the mirrored state for one accepted transaction, queue any frame results
    task automatic viterbi_step(input logic [1:0] f, input logic [3:0] src,
                                input logic [3:0] dst, input logic [31:0] p);
        int          q;
        logic [63:0] best;
        logic [63:0] cand;
        logic [4:0]  ptr;
        logic [31:0] sc;
        logic [63:0] scl;
        frame_result_t r;
        q = states_used();
        case (f)
            FUNC_PRIOR:
            begin
                prior_tab[dst] = p;
                prior_w[dst] = 1;
            end
            FUNC_TRANS:
            begin
                trans_tab[{src, dst}] = p;
                trans_w[{src, dst}] = 1;
            end
            FUNC_START:
            begin
                first_frame = 1;
                frame_sum = '0;
            end
            default:
            begin
                if (dst < q)
                begin
                    if (first_frame)
                    begin
                        sc = 32'(prod64(prior_tab[dst], p) >> 32);
                        ptr = '0;
                    end
                    else
                    begin
                        best = prod64(prev_score[0], trans_tab[{4'd0, dst}]);
                        ptr = 5'd1;
                        for (int k = 1; k < q; k++)
                        begin
                            cand = prod64(prev_score[k], trans_tab[{k[3:0], dst}]);
                            if (cand > best)
                            begin
                                best = cand;
                                ptr = 5'(k + 1);
                            end
                        end
                        sc = 32'(prod64(best[63:32], p) >> 32);
                    end
                    cur_score[dst] = sc;
                    cur_ptr[dst] = ptr;
                    cur_w[dst] = 1;
                    frame_sum = frame_sum + 37'(sc);
                    if (dst == q - 1)
                    begin
                        scl = '0;
                        if (scale_reg)
                        begin
                            scl = frame_reciprocal(frame_sum);
                        end
                        for (int k = 0; k < q; k++)
                        begin
                            if (scale_reg)
                            begin
                                cur_score[k] = normalised(cur_score[k], frame_sum);
                            end
                            prev_score[k] = cur_score[k];
                            prev_w[k] = 1;
                            r.st = k[3:0];
                            r.score = cur_score[k];
                            r.ptr = cur_ptr[k];
                            r.scale = scl;
                            r.last = (k == q - 1);
                            frame_results_q.push_back(r);
                        end
                        first_frame = 0;
                        frame_sum = '0;
                    end
                end
            end
        endcase
    endtask

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, field, got, want);
    endtask

    // result side: check accepted transactions, then choose ready for the next edge
    always @(posedge clk)
    begin
        frame_result_t w;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** hmm_viterbi_forward_pass: FAILED **");
            $finish;
        end
        if (rst_n && result_valid && result_ready)
        begin
            if (frame_results_q.size() == 0)
            begin
                report_mismatch("unexpected result", 64'(state_index), 64'd0);
            end
            else
            begin
                w = frame_results_q.pop_front();
                if (state_index !== w.st)
                    report_mismatch("state_index", 64'(state_index), 64'(w.st));
                if (best_score !== w.score)
                    report_mismatch("best_score", 64'(best_score), 64'(w.score));
                if (back_pointer !== w.ptr)
                    report_mismatch("back_pointer", 64'(back_pointer), 64'(w.ptr));
                if (frame_scale !== w.scale)
                    report_mismatch("frame_scale", frame_scale, w.scale);
                if (last_of_frame !== w.last)
                    report_mismatch("last_of_frame", 64'(last_of_frame), 64'(w.last));
            end
        end
        if (recv_hold > 0)
        begin
            recv_hold--;
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // one transaction on the item channel, with random idle cycles ahead of it
    task automatic send_item(input logic [1:0] f, input logic [3:0] src,
                             input logic [3:0] dst, input logic [31:0] p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        func <= f;
        from_state <= src;
        to_state <= dst;
        prob_value <= p;
        do
        begin
            @(posedge clk);
        end
        while (!item_ready);
        viterbi_step(f, src, dst, p);
        if (f == FUNC_START)
        begin
            obs_next = 0;
        end
        else if (f == FUNC_OBS && dst < states_used())
        begin
            obs_next = (dst + 1) % states_used();
        end
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (frame_results_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    // register write: setup cycle then access cycle
    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_NUM_STATES)
        begin
            num_states_reg = data[4:0];
        end
        else
        begin
            scale_reg = data[0];
        end
    endtask

    function automatic logic [31:0] rand_prob();
        case ($urandom_range(9))
            0:       return 32'hFFFF_FFFF;
            1:       return 32'h0;
            2:       return $urandom_range(255);
            3, 4, 5: return {1'b1, 31'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    // an observation only if every entry it reads has been written, else a restart
    function automatic bit obs_readable(input int s);
        int q;
        q = states_used();
        if (first_frame)
        begin
            return prior_w[s];
        end
        for (int k = 0; k < q; k++)
        begin
            if (!prev_w[k] || !trans_w[{k[3:0], s[3:0]}])
            begin
                return 0;
            end
        end
        return 1;
    endfunction

    task automatic send_observation(input int s);
        int q;
        int t;
        q = states_used();
        t = s;
        if (t == q - 1)
        begin
            for (int k = 0; k < q - 1; k++)
            begin
                if (!cur_w[k])
                begin
                    t = k;
                    break;
                end
            end
        end
        if (obs_readable(t))
        begin
            send_item(FUNC_OBS, 4'($urandom), 4'(t), rand_prob());
        end
        else
        begin
            send_item(FUNC_START, 4'($urandom), 4'($urandom), $urandom);
        end
    endtask

    // one random phase: settings, table fill, then mostly ordered frames with noise
    task automatic run_phase(input int ns, input int sc, input int s_idle, input int r_idle,
                             input int n_steps, input bit hold);
        int q;
        int r;
        int s;
        wait_drained();
        reg_write(ADDR_NUM_STATES, 32'(ns));
        reg_write(ADDR_SCALE_EN, 32'(sc));
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        q = states_used();
        send_item(FUNC_START, '0, '0, '0);
        for (int d = 0; d < q; d++)
        begin
            if (!prior_w[d] || $urandom_range(3) == 0)
            begin
                send_item(FUNC_PRIOR, 4'($urandom), 4'(d), rand_prob());
            end
            // full transition fill only for small state counts, large ones stay first-frame
            if (q <= 8)
            begin
                for (int f = 0; f < q; f++)
                begin
                    if (!trans_w[{f[3:0], d[3:0]}] || $urandom_range(7) == 0)
                    begin
                        send_item(FUNC_TRANS, 4'(f), 4'(d), rand_prob());
                    end
                end
            end
        end
        if (hold)
        begin
            recv_hold = 600;
        end
        for (int i = 0; i < n_steps; i++)
        begin
            r = $urandom_range(99);
            if (r < 5)
            begin
                send_item(FUNC_START, 4'($urandom), 4'($urandom), $urandom);
            end
            else if (r < 10 && q < 16)
            begin
                send_item(FUNC_OBS, 4'($urandom), 4'($urandom_range(15, q)), $urandom);
            end
            else if (r < 14)
            begin
                send_item(FUNC_PRIOR, 4'($urandom), 4'($urandom), rand_prob());
            end
            else if (r < 18)
            begin
                send_item(FUNC_TRANS, 4'($urandom), 4'($urandom), rand_prob());
            end
            else
            begin
                s = obs_next;
                if (r < 24)
                begin
                    s = $urandom_range(q - 1);
                end
                send_observation(s);
            end
        end
    endtask

    // directed rows: extremes, ignored index, double observation, zero sum with scaling
    stim_row_t rows[$];

    function automatic stim_row_t mk(input row_kind_t k, input logic [1:0] f,
                                     input logic [3:0] src, input logic [3:0] dst,
                                     input logic [31:0] v);
        stim_row_t r;
        r.kind = k;
        r.fn = f;
        r.src = src;
        r.dst = dst;
        r.val = v;
        r.glance = 0;
        r.g_score = '0;
        r.g_ptr = '0;
        r.g_scale = '0;
        return r;
    endfunction

    function automatic stim_row_t mk_glance(input logic [3:0] dst, input logic [31:0] v,
                                            input logic [31:0] gs, input logic [63:0] gscl);
        stim_row_t r;
        r = mk(ROW_ITEM, FUNC_OBS, 4'd0, dst, v);
        r.glance = 1;
        r.g_score = gs;
        r.g_ptr = '0;
        r.g_scale = gscl;
        return r;
    endfunction

    initial
    begin
        frame_result_t g;
        frame_sum = '0;
        first_frame = 1;
        num_states_reg = 5'd16;
        scale_reg = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows.push_back(mk(ROW_REG, FUNC_PRIOR, 4'd0, 4'd0, 32'd2));
        rows.push_back(mk(ROW_REG, FUNC_TRANS, 4'd0, 4'd0, 32'd0));
        rows.push_back(mk(ROW_ITEM, FUNC_PRIOR, 4'd0, 4'd0, 32'hFFFF_FFFF));
        rows.push_back(mk(ROW_ITEM, FUNC_PRIOR, 4'd0, 4'd1, 32'h0));
        rows.push_back(mk(ROW_ITEM, FUNC_PRIOR, 4'd15, 4'd15, 32'h1234_5678));
        rows.push_back(mk(ROW_ITEM, FUNC_TRANS, 4'd0, 4'd0, 32'hFFFF_FFFF));
        rows.push_back(mk(ROW_ITEM, FUNC_TRANS, 4'd0, 4'd1, 32'h8000_0000));
        rows.push_back(mk(ROW_ITEM, FUNC_TRANS, 4'd1, 4'd0, 32'h0));
        rows.push_back(mk(ROW_ITEM, FUNC_TRANS, 4'd1, 4'd1, 32'h8000_0000));
        rows.push_back(mk(ROW_ITEM, FUNC_TRANS, 4'd15, 4'd15, 32'hFFFF_FFFF));
        rows.push_back(mk(ROW_ITEM, FUNC_START, 4'd0, 4'd0, 32'h0));
        rows.push_back(mk(ROW_ITEM, FUNC_OBS, 4'd0, 4'd3, 32'hFFFF_FFFF));
        rows.push_back(mk(ROW_ITEM, FUNC_OBS, 4'd0, 4'd0, 32'hFFFF_FFFF));
        rows.push_back(mk(ROW_ITEM, FUNC_OBS, 4'd0, 4'd0, 32'hFFFF_FFFF));
        rows.push_back(mk_glance(4'd1, 32'hFFFF_FFFF, 32'h0, 64'h0));
        rows.push_back(mk(ROW_ITEM, FUNC_OBS, 4'd0, 4'd0, 32'h8000_0000));
        rows.push_back(mk(ROW_ITEM, FUNC_OBS, 4'd0, 4'd1, 32'hFFFF_FFFF));
        rows.push_back(mk(ROW_ITEM, FUNC_OBS, 4'd0, 4'd1, 32'hFFFF_FFFF));
        rows.push_back(mk(ROW_REG, FUNC_TRANS, 4'd0, 4'd0, 32'd1));
        rows.push_back(mk(ROW_ITEM, FUNC_START, 4'd0, 4'd0, 32'h0));
        rows.push_back(mk(ROW_ITEM, FUNC_OBS, 4'd0, 4'd0, 32'h0));
        rows.push_back(mk_glance(4'd1, 32'h0, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF));
        rows.push_back(mk(ROW_ITEM, FUNC_OBS, 4'd0, 4'd0, 32'hFFFF_FFFF));
        rows.push_back(mk(ROW_ITEM, FUNC_OBS, 4'd0, 4'd1, 32'hFFFF_FFFF));
        rows.push_back(mk(ROW_REG, FUNC_PRIOR, 4'd0, 4'd0, 32'd0));
        rows.push_back(mk(ROW_ITEM, FUNC_START, 4'd0, 4'd0, 32'h0));
        rows.push_back(mk(ROW_ITEM, FUNC_OBS, 4'd9, 4'd0, 32'hFFFF_FFFF));

        // register rows: func picks the register, prob the value
        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_REG)
            begin
                wait_drained();
                reg_write((rows[i].fn == FUNC_PRIOR) ? ADDR_NUM_STATES : ADDR_SCALE_EN,
                          rows[i].val);
            end
            else
            begin
                send_item(rows[i].fn, rows[i].src, rows[i].dst, rows[i].val);
                if (rows[i].glance)
                begin
                    g = frame_results_q.pop_back();
                    g.score = rows[i].g_score;
                    g.ptr = rows[i].g_ptr;
                    g.scale = rows[i].g_scale;
                    frame_results_q.push_back(g);
                end
            end
        end

        run_phase(3, 0, 18, 60, 30, 0);
        run_phase(31, 1, 18, 60, 40, 0);
        run_phase(5, 1, 60, 18, 40, 0);
        run_phase(1, 0, 60, 18, 20, 0);
        run_phase(16, 0, 0, 0, 36, 0);
        run_phase(4, 0, 0, 0, 30, 1);
        wait_drained();

        if (mismatches == 0 && frame_results_q.size() == 0)
        begin
            $display("** hmm_viterbi_forward_pass: PASSED **");
        end
        else
        begin
            $display("** hmm_viterbi_forward_pass: FAILED **");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/hvf_pkg.sv
rtl/core/hvf_ram.sv
rtl/core/hvf_divider.sv
rtl/core/hvf_front.sv
rtl/core/hvf_back.sv
rtl/core/hmm_viterbi_forward_pass.sv
bench/hmm_viterbi_forward_pass_tb.sv
